// ===== src/dlif_pkg.sv =====
// shared types and constants of the dynamic lif neuron pool
package dlif_pkg;

	typedef enum logic [1:0] {
		MODE_CURRENT = 2'd0,
		MODE_END     = 2'd1,
		MODE_CLEAR   = 2'd2,
		MODE_NONE    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		RT_IGNORED   = 2'd0,
		RT_STAGED    = 2'd1,
		RT_ALLOCATED = 2'd2,
		RT_REJECTED  = 2'd3
	} route_t;

	typedef enum logic [1:0] {
		REG_INV_TAU       = 2'd0,
		REG_V_THRESHOLD   = 2'd1,
		REG_AGE_THRESHOLD = 2'd2,
		REG_POT_THRESHOLD = 2'd3
	} reg_idx_t;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_FIRE   = 1'b1;

	typedef struct packed {
		logic [1:0]         mode;
		logic [7:0]         neuron_index;
		logic signed [31:0] input_current;
	} in_t;

	typedef struct packed {
		logic        kind;
		logic [1:0]  route_status;
		logic [7:0]  fired_id;
		logic        fired_valid;
		logic        last;
		logic [5:0]  live_count;
		logic [5:0]  peak_count;
		logic [31:0] reject_count;
		logic [31:0] prune_count;
		logic [31:0] alloc_count;
	} out_t;

	typedef struct packed {
		logic accept;
		logic route_rd;
		logic route_wr;
		logic end_start;
		logic leak_mul;
		logic leak_upd;
		logic report;
		logic scan;
	} cmd_t;

	typedef struct packed {
		logic slot_last;
		logic nf_zero;
		logic scan_done;
	} sts_t;

endpackage

// ===== src/dlif_ctrl.sv =====
// controller state machine of the dynamic lif neuron pool
module dlif_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [1:0]     mode,
	input  dlif_pkg::sts_t sts,
	output dlif_pkg::cmd_t cmd,
	output logic           busy
);
	import dlif_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE      = 8'b0000_0001,
		S_ROUTE_RD  = 8'b0000_0010,
		S_ROUTE_WR  = 8'b0000_0100,
		S_END_START = 8'b0000_1000,
		S_LEAK_MUL  = 8'b0001_0000,
		S_LEAK_UPD  = 8'b0010_0000,
		S_REPORT    = 8'b0100_0000,
		S_SCAN      = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (mode == MODE_CURRENT) state_d = S_ROUTE_RD;
					else if (mode == MODE_END) state_d = S_END_START;
				end
			end
			S_ROUTE_RD:  state_d = S_ROUTE_WR;
			S_ROUTE_WR:  state_d = S_IDLE;
			S_END_START: state_d = S_LEAK_MUL;
			S_LEAK_MUL:  state_d = S_LEAK_UPD;
			S_LEAK_UPD:  state_d = sts.slot_last ? S_REPORT : S_LEAK_MUL;
			S_REPORT:    state_d = sts.nf_zero ? S_IDLE : S_SCAN;
			S_SCAN:      state_d = sts.scan_done ? S_IDLE : S_SCAN;
			default:     state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		cmd           = '0;
		cmd.accept    = accept;
		cmd.route_rd  = (state_q == S_ROUTE_RD);
		cmd.route_wr  = (state_q == S_ROUTE_WR);
		cmd.end_start = (state_q == S_END_START);
		cmd.leak_mul  = (state_q == S_LEAK_MUL);
		cmd.leak_upd  = (state_q == S_LEAK_UPD);
		cmd.report    = (state_q == S_REPORT);
		cmd.scan      = (state_q == S_SCAN);
	end

endmodule

// ===== src/dlif_dp.sv =====
// datapath of the dynamic lif neuron pool: slots, maps, free ring, leak unit, report scan
module dlif_dp #(
	parameter int PHYS_SLOTS      = 32,
	parameter int LOGICAL_NEURONS = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  dlif_pkg::cmd_t cmd,
	input  dlif_pkg::in_t  item,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_addr,
	input  logic [31:0]    cfg_wdata,
	output dlif_pkg::sts_t sts,
	output dlif_pkg::out_t result,
	output logic           result_valid
);
	import dlif_pkg::*;

	localparam int SW     = $clog2(PHYS_SLOTS);
	localparam int CW     = $clog2(PHYS_SLOTS + 1);
	localparam int RW     = $clog2(PHYS_SLOTS + 1);
	localparam int RDEPTH = PHYS_SLOTS + 1;
	localparam int LW     = $clog2(LOGICAL_NEURONS);
	localparam int SCAN_N = (LOGICAL_NEURONS < 256) ? LOGICAL_NEURONS : 256;
	localparam int QW     = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;

	// configuration
	logic [15:0]        inv_tau_q, age_thr_q;
	logic signed [31:0] v_thr_q, pot_thr_q;

	// slot state
	logic signed [31:0] membrane_q [PHYS_SLOTS];
	logic signed [31:0] staged_q   [PHYS_SLOTS];
	logic [15:0]        age_q      [PHYS_SLOTS];
	logic [7:0]         owner_q    [PHYS_SLOTS];
	logic [PHYS_SLOTS-1:0]      valid_q, fire_q;
	logic [LOGICAL_NEURONS-1:0] mapped_q;
	logic [SW-1:0]      l2s_mem [LOGICAL_NEURONS];
	logic [SW-1:0]      l2s_rd_q;

	// free ring
	logic [SW-1:0]      ring_mem [RDEPTH];
	logic [RDEPTH-1:0]  ring_wr_q;
	logic [SW-1:0]      ring_rd_q, ring_rst_q;
	logic               ring_hit_q;
	logic [RW-1:0]      head_q, tail_q;

	logic [CW-1:0]      live_q, peak_q, nf_q, emit_q;
	logic [31:0]        rejects_q, prunes_q, allocs_q;
	logic               step_open_q;

	in_t                item_q;
	logic [SW-1:0]      slot_q;
	logic [QW-1:0]      scan_q, id_s1;
	logic               chk_s1, map_s1;

	logic signed [49:0] prod_s1;
	logic signed [31:0] v_s1;

	logic               res_v_q, res_kind_q, res_fv_q, res_last_q;
	logic [1:0]         res_st_q;
	logic [7:0]         res_id_q;

	// combinational helpers
	logic signed [32:0] diff;
	logic signed [16:0] gain;
	logic signed [49:0] prod;
	logic signed [33:0] delta;
	logic signed [34:0] nv_wide;
	logic signed [31:0] nv;
	logic               in_range, ring_empty, hit, hit_last;
	logic [SW-1:0]      ring_val;
	logic [LW-1:0]      idx_l, rd_addr;

	function automatic logic [RW-1:0] ring_next(input logic [RW-1:0] p);
		logic [RW-1:0] r;
		if (p == RW'(PHYS_SLOTS)) r = '0;
		else r = p + RW'(1);
		return r;
	endfunction

	function automatic logic [31:0] sat_inc(input logic [31:0] c);
		return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
	endfunction

	assign diff     = {staged_q[slot_q][31], staged_q[slot_q]}
	                - {membrane_q[slot_q][31], membrane_q[slot_q]};
	assign gain     = $signed({1'b0, inv_tau_q});
	assign prod     = diff * gain;
	assign delta    = prod_s1[49:16];
	assign nv_wide  = {{3{v_s1[31]}}, v_s1} + {delta[33], delta};
	assign nv       = (nv_wide > 35'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
	                  (nv_wide < -35'sh0_8000_0000) ? 32'sh8000_0000 : nv_wide[31:0];
	assign in_range = (int'(item_q.neuron_index) < LOGICAL_NEURONS);
	assign idx_l    = LW'(item_q.neuron_index);
	assign rd_addr  = cmd.scan ? LW'(scan_q) : idx_l;
	assign ring_empty = (head_q == tail_q);
	assign ring_val = ring_hit_q ? ring_rd_q : ring_rst_q;
	assign hit      = chk_s1 && map_s1 && fire_q[l2s_rd_q];
	assign hit_last = (emit_q + CW'(1)) == nf_q;

	assign sts.slot_last = (slot_q == SW'(PHYS_SLOTS - 1));
	assign sts.nf_zero   = (nf_q == '0);
	assign sts.scan_done = cmd.scan && hit && hit_last;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_tau_q <= 16'd6554;
			v_thr_q   <= 32'sd65536;
			age_thr_q <= 16'd16;
			pot_thr_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_INV_TAU:       inv_tau_q <= cfg_wdata[15:0];
				REG_V_THRESHOLD:   v_thr_q   <= cfg_wdata;
				REG_AGE_THRESHOLD: age_thr_q <= cfg_wdata[15:0];
				REG_POT_THRESHOLD: pot_thr_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (cmd.route_wr && item_q.input_current != '0 && in_range
		    && !mapped_q[idx_l] && !ring_empty)
			l2s_mem[idx_l] <= ring_val;
		l2s_rd_q <= l2s_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.leak_upd && valid_q[slot_q] && !(nv >= v_thr_q)
		    && (age_q[slot_q] >= age_thr_q || nv <= pot_thr_q))
			ring_mem[tail_q] <= slot_q;
		ring_rd_q  <= ring_mem[head_q];
		ring_rst_q <= (head_q == RW'(PHYS_SLOTS)) ? '0 : SW'(head_q);
	end

	// slot payload arrays
	always_ff @(posedge clk) begin
		if (cmd.route_wr && item_q.input_current != '0 && in_range) begin
			if (mapped_q[idx_l]) begin
				staged_q[l2s_rd_q] <= item_q.input_current;
			end else if (!ring_empty) begin
				staged_q[ring_val]   <= item_q.input_current;
				membrane_q[ring_val] <= '0;
				owner_q[ring_val]    <= item_q.neuron_index;
			end
		end
		if (cmd.leak_mul) begin
			prod_s1 <= prod;
			v_s1    <= membrane_q[slot_q];
		end
		if (cmd.leak_upd && valid_q[slot_q]) begin
			staged_q[slot_q] <= '0;
			if (nv >= v_thr_q) membrane_q[slot_q] <= '0;
			else membrane_q[slot_q] <= nv;
		end
		if (cmd.accept) item_q <= item;
		if (cmd.scan) begin
			id_s1  <= scan_q;
			map_s1 <= mapped_q[LW'(scan_q)];
		end
	end

	// control and bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			fire_q      <= '0;
			mapped_q    <= '0;
			ring_wr_q   <= '0;
			ring_hit_q  <= 1'b0;
			head_q      <= '0;
			tail_q      <= RW'(PHYS_SLOTS);
			live_q      <= '0;
			peak_q      <= '0;
			nf_q        <= '0;
			emit_q      <= '0;
			rejects_q   <= '0;
			prunes_q    <= '0;
			allocs_q    <= '0;
			step_open_q <= 1'b0;
			slot_q      <= '0;
			scan_q      <= '0;
			chk_s1      <= 1'b0;
			res_v_q     <= 1'b0;
			res_kind_q  <= KIND_STATUS;
			res_st_q    <= RT_IGNORED;
			res_id_q    <= '0;
			res_fv_q    <= 1'b0;
			res_last_q  <= 1'b0;
			for (int i = 0; i < PHYS_SLOTS; i++) age_q[i] <= '0;
		end else begin
			res_v_q    <= (cmd.accept && (item.mode == MODE_CLEAR || item.mode == MODE_NONE))
			              || cmd.route_wr || (cmd.report && nf_q == '0) || (cmd.scan && hit);
			ring_hit_q <= ring_wr_q[head_q];

			if (cmd.accept && (item.mode == MODE_CLEAR || item.mode == MODE_NONE)) begin
				if (item.mode == MODE_CLEAR) begin
					peak_q    <= live_q;
					rejects_q <= '0;
					prunes_q  <= '0;
					allocs_q  <= '0;
				end
				res_kind_q <= KIND_STATUS;
				res_st_q   <= RT_IGNORED;
				res_id_q   <= '0;
				res_fv_q   <= 1'b0;
				res_last_q <= 1'b1;
			end

			if ((cmd.route_rd || cmd.end_start) && !step_open_q) begin
				for (int i = 0; i < PHYS_SLOTS; i++)
					if (valid_q[i] && age_q[i] != 16'hFFFF) age_q[i] <= age_q[i] + 16'd1;
			end
			if (cmd.route_rd) step_open_q <= 1'b1;

			if (cmd.route_wr) begin
				res_kind_q <= KIND_STATUS;
				res_id_q   <= '0;
				res_fv_q   <= 1'b0;
				res_last_q <= 1'b1;
				if (item_q.input_current == '0 || !in_range) begin
					res_st_q <= RT_IGNORED;
				end else if (mapped_q[idx_l]) begin
					age_q[l2s_rd_q] <= '0;
					res_st_q        <= RT_STAGED;
				end else if (ring_empty) begin
					rejects_q <= sat_inc(rejects_q);
					res_st_q  <= RT_REJECTED;
				end else begin
					head_q            <= ring_next(head_q);
					mapped_q[idx_l]   <= 1'b1;
					valid_q[ring_val] <= 1'b1;
					age_q[ring_val]   <= '0;
					allocs_q          <= sat_inc(allocs_q);
					live_q            <= live_q + CW'(1);
					if (live_q + CW'(1) > peak_q) peak_q <= live_q + CW'(1);
					res_st_q          <= RT_ALLOCATED;
				end
			end

			if (cmd.end_start) begin
				step_open_q <= 1'b0;
				fire_q      <= '0;
				nf_q        <= '0;
				slot_q      <= '0;
			end

			if (cmd.leak_upd) begin
				if (valid_q[slot_q]) begin
					if (nv >= v_thr_q) begin
						age_q[slot_q]  <= '0;
						fire_q[slot_q] <= 1'b1;
						nf_q           <= nf_q + CW'(1);
					end else if (age_q[slot_q] >= age_thr_q || nv <= pot_thr_q) begin
						valid_q[slot_q]               <= 1'b0;
						mapped_q[LW'(owner_q[slot_q])] <= 1'b0;
						ring_wr_q[tail_q]             <= 1'b1;
						tail_q                        <= ring_next(tail_q);
						if (live_q != '0) live_q <= live_q - CW'(1);
						prunes_q                      <= sat_inc(prunes_q);
					end
				end
				if (!sts.slot_last) slot_q <= slot_q + SW'(1);
			end

			if (cmd.report) begin
				scan_q <= '0;
				emit_q <= '0;
				chk_s1 <= 1'b0;
				if (nf_q == '0) begin
					res_kind_q <= KIND_FIRE;
					res_st_q   <= RT_IGNORED;
					res_id_q   <= '0;
					res_fv_q   <= 1'b0;
					res_last_q <= 1'b1;
				end
			end

			if (cmd.scan) begin
				chk_s1 <= 1'b1;
				if (scan_q != QW'(SCAN_N - 1)) scan_q <= scan_q + QW'(1);
				if (hit) begin
					emit_q     <= emit_q + CW'(1);
					res_kind_q <= KIND_FIRE;
					res_st_q   <= RT_IGNORED;
					res_id_q   <= 8'(id_s1);
					res_fv_q   <= 1'b1;
					res_last_q <= hit_last;
				end
			end
		end
	end

	assign result_valid        = res_v_q;
	assign result.kind         = res_kind_q;
	assign result.route_status = res_st_q;
	assign result.fired_id     = res_id_q;
	assign result.fired_valid  = res_fv_q;
	assign result.last         = res_last_q;
	assign result.live_count   = 6'(live_q);
	assign result.peak_count   = 6'(peak_q);
	assign result.reject_count = rejects_q;
	assign result.prune_count  = prunes_q;
	assign result.alloc_count  = allocs_q;

`ifndef SYNTHESIS
	logic [RW:0] free_cnt;
	assign free_cnt = (tail_q >= head_q) ? {1'b0, tail_q} - {1'b0, head_q}
	                : {1'b0, tail_q} + (RW+1)'(RDEPTH) - {1'b0, head_q};

	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= CW'(PHYS_SLOTS))
		else $error("live slot count above pool size");

	a_ring_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(RW+1)'(live_q) + free_cnt == (RW+1)'(PHYS_SLOTS))
		else $error("free ring and live count disagree");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_STATUS |-> result.last)
		else $error("status transaction without last");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> emit_q < nf_q)
		else $error("more fire reports than fired slots");
`endif

endmodule

// ===== src/dynamic_lif_neuron_pool_top.sv =====
// top level of the dynamic lif neuron pool
//
// channel   direction  handshake                       payload
// item      in         start high while busy low       item (in_t)
// result    out        result_valid for one cycle      result (out_t)
// config    in         cfg_we, no wait                 cfg_addr, cfg_wdata
//
// current item: controller states route read, route write, then status transaction
// clear or unused mode: busy stays low, status transaction on the next cycle
// end item: end start, leak multiply and leak update per slot, then report scan
// reads the logical map once per id up to the last fired id; leak unit is serial
// reset is asynchronous; results cannot be held off by the receiver
module dynamic_lif_neuron_pool_top #(
	parameter int PHYS_SLOTS      = 32,
	parameter int LOGICAL_NEURONS = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  dlif_pkg::in_t  item,
	output dlif_pkg::out_t result,
	output logic           result_valid,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_addr,
	input  logic [31:0]    cfg_wdata
);
	import dlif_pkg::*;

	cmd_t cmd;
	sts_t sts;

	dlif_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (item.mode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	dlif_dp #(
		.PHYS_SLOTS      (PHYS_SLOTS),
		.LOGICAL_NEURONS (LOGICAL_NEURONS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.sts          (sts),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule
